// ===== rtl/assert_macros.svh =====
// Assertion macros used by the console writer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Types and constants of the text console writer.
package tcw_pkg;

	localparam int COLOR_W   = 4;
	localparam int REG_IDX_W = 1;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_FG = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BG = 1'b1;

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] RETURN_CHAR  = 8'h0D;

	localparam logic [COLOR_W-1:0] RESET_FG = 4'h0;
	localparam logic [COLOR_W-1:0] RESET_BG = 4'hF;
	localparam logic [15:0] RESET_CELL = {RESET_BG, RESET_FG, BLANK_CHAR};

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
	} result_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_NEWLINE,
		OP_RETURN,
		OP_CHAR,
		OP_CLEAR,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] char_code;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} op_t;

	typedef struct packed {
		logic                 wr_en;
		logic [REG_IDX_W-1:0] index;
		logic [COLOR_W-1:0]   data;
	} cfg_wr_t;

endpackage

// ===== rtl/tcw_fifo.sv =====
// Small synchronous queue used between the stages of the console writer.
module tcw_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/tcw_front.sv =====
// Front stage of the console writer: takes input transactions and classifies them.
module tcw_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcw_pkg::item_t  item,
	output logic            full,
	input  logic            init_busy,
	output logic            op_push,
	output tcw_pkg::op_t    op,
	input  logic            op_full
);

	logic         valid_s1;
	tcw_pkg::op_t op_s1;
	tcw_pkg::op_t op_cls;
	logic         accept;
	logic         read_in_range;

	assign full    = (valid_s1 && op_full) || init_busy;
	assign accept  = push && !full;
	assign op_push = valid_s1 && !op_full;
	assign op      = op_s1;

	assign read_in_range = (32'(item.read_col) < COLS) && (32'(item.read_row) < ROWS);

	always_comb begin
		op_cls.char_code = item.char_code;
		op_cls.read_col  = item.read_col;
		op_cls.read_row  = item.read_row;
		case (item.cmd)
			tcw_pkg::CMD_PUT: begin
				if (item.char_code == tcw_pkg::NEWLINE_CHAR) begin
					op_cls.kind = tcw_pkg::OP_NEWLINE;
				end else if (item.char_code == tcw_pkg::RETURN_CHAR) begin
					op_cls.kind = tcw_pkg::OP_RETURN;
				end else begin
					op_cls.kind = tcw_pkg::OP_CHAR;
				end
			end
			tcw_pkg::CMD_CLEAR: op_cls.kind = tcw_pkg::OP_CLEAR;
			tcw_pkg::CMD_READ: begin
				op_cls.kind = read_in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			end
			default: op_cls.kind = tcw_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (op_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_cls;
		end
	end

endmodule

// ===== rtl/tcw_back.sv =====
// Back end of the console writer: screen memory, cursor, colours and command sequencer.
`include "assert_macros.svh"

module tcw_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_pkg::cfg_wr_t  cfg,
	input  logic              op_valid,
	input  tcw_pkg::op_t      op,
	output logic              op_pop,
	input  logic              res_full,
	output logic              res_push,
	output tcw_pkg::result_t  res,
	output logic              init_busy
);

	localparam int CELLS      = COLS * ROWS;
	localparam int COPY_CELLS = (ROWS - 1) * COLS;
	localparam int AW         = $clog2(CELLS);
	localparam int CW         = $clog2(COLS + 1);
	localparam int RW         = $clog2(ROWS + 1);

	localparam logic [AW-1:0] COLS_A    = AW'(COLS);
	localparam logic [AW-1:0] LAST_A    = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'(COPY_CELLS - 1);
	localparam logic [AW-1:0] BOTTOM_A  = AW'(COPY_CELLS);
	localparam logic [CW-1:0] COLS_C    = CW'(COLS);
	localparam logic [RW-1:0] ROWS_C    = RW'(ROWS);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                idx_q;
	logic [CW-1:0]                cur_col_q;
	logic [RW-1:0]                cur_row_q;
	logic [tcw_pkg::COLOR_W-1:0]  fg_q;
	logic [tcw_pkg::COLOR_W-1:0]  bg_q;
	tcw_pkg::op_t                 op_q;
	logic                         copy_valid_s1;
	logic [AW-1:0]                copy_addr_s1;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rdata_q;

	logic [7:0]    attr;
	logic [15:0]   blank_cell;
	logic          col_full;
	logic          row_below;
	logic          do_wrap;
	logic [CW-1:0] wrap_col;
	logic [RW-1:0] wrap_row;
	logic          need_scroll;
	logic [AW-1:0] put_addr;
	logic [AW-1:0] read_addr;
	logic          take_op;

	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic [15:0]   cell_rd;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic [AW-1:0] rd_addr;

	assign attr        = {bg_q, fg_q};
	assign blank_cell  = {attr, tcw_pkg::BLANK_CHAR};
	assign col_full    = (cur_col_q >= COLS_C);
	assign row_below   = (cur_row_q >= ROWS_C);
	assign do_wrap     = col_full && !row_below;
	assign wrap_col    = do_wrap ? '0 : cur_col_q;
	assign wrap_row    = do_wrap ? cur_row_q + 1'b1 : cur_row_q;
	assign need_scroll = (wrap_row >= ROWS_C);
	assign put_addr    = AW'(cur_row_q) * COLS_A + AW'(cur_col_q);
	assign read_addr   = AW'(op.read_row) * COLS_A + AW'(op.read_col);
	assign take_op     = (state_q == ST_IDLE) && op_valid && !res_full;
	assign init_busy   = (state_q == ST_INIT);

	always_comb begin
		op_pop   = 1'b0;
		res_push = 1'b0;
		cell_rd  = '0;
		nxt_col  = cur_col_q;
		nxt_row  = cur_row_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = blank_cell;
		rd_addr  = read_addr;
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = tcw_pkg::RESET_CELL;
			end
			ST_IDLE: begin
				if (take_op) begin
					op_pop = 1'b1;
					case (op.kind)
						tcw_pkg::OP_NEWLINE: begin
							if (!row_below) begin
								nxt_row = cur_row_q + 1'b1;
							end
							nxt_col  = '0;
							res_push = 1'b1;
						end
						tcw_pkg::OP_RETURN: begin
							nxt_col  = '0;
							res_push = 1'b1;
						end
						tcw_pkg::OP_CHAR: begin
							if (!need_scroll) begin
								nxt_col = wrap_col;
								nxt_row = wrap_row;
							end
						end
						tcw_pkg::OP_READ, tcw_pkg::OP_CLEAR: begin
						end
						default: res_push = 1'b1;
					endcase
				end
			end
			ST_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = put_addr;
				wr_data  = {attr, op_q.char_code};
				nxt_col  = cur_col_q + 1'b1;
				res_push = 1'b1;
			end
			ST_READ: begin
				cell_rd  = rdata_q;
				res_push = 1'b1;
			end
			ST_COPY: begin
				rd_addr = idx_q + COLS_A;
			end
			ST_BLANK: begin
				if (!copy_valid_s1) begin
					wr_en = 1'b1;
					if (idx_q == LAST_A) begin
						nxt_row = LAST_ROW;
						nxt_col = '0;
					end
				end
			end
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (idx_q == LAST_A) begin
					nxt_col  = '0;
					nxt_row  = '0;
					res_push = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (copy_valid_s1) begin
			wr_en   = 1'b1;
			wr_addr = copy_addr_s1;
			wr_data = rdata_q;
		end
		res.cell_value = cell_rd;
		res.cursor_col = 7'(nxt_col);
		res.cursor_row = 5'(nxt_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			idx_q         <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			fg_q          <= tcw_pkg::RESET_FG;
			bg_q          <= tcw_pkg::RESET_BG;
			copy_valid_s1 <= 1'b0;
		end else begin
			cur_col_q     <= nxt_col;
			cur_row_q     <= nxt_row;
			copy_valid_s1 <= (state_q == ST_COPY);
			if (cfg.wr_en) begin
				case (cfg.index)
					tcw_pkg::REG_FG: fg_q <= cfg.data;
					tcw_pkg::REG_BG: bg_q <= cfg.data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_INIT: begin
					if (idx_q == LAST_A) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (take_op) begin
						case (op.kind)
							tcw_pkg::OP_READ: state_q <= ST_READ;
							tcw_pkg::OP_CLEAR: begin
								idx_q   <= '0;
								state_q <= ST_CLEAR;
							end
							tcw_pkg::OP_CHAR: begin
								if (need_scroll) begin
									idx_q   <= '0;
									state_q <= ST_COPY;
								end else begin
									state_q <= ST_PUT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PUT, ST_READ: state_q <= ST_IDLE;
				ST_COPY: begin
					if (idx_q == COPY_LAST) begin
						idx_q   <= BOTTOM_A;
						state_q <= ST_BLANK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (!copy_valid_s1) begin
						if (idx_q == LAST_A) begin
							state_q <= ST_PUT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					if (idx_q == LAST_A) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
		copy_addr_s1 <= idx_q;
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	`TCW_ASSERT(a_row_bound, clk, arst_n, cur_row_q <= ROWS_C, "cursor row beyond screen")
	`TCW_ASSERT(a_put_in_screen, clk, arst_n,
		(state_q == ST_PUT) |-> (cur_row_q < ROWS_C) && (cur_col_q < COLS_C),
		"cell write outside screen")
	`TCW_ASSERT_NEVER(a_res_overflow, clk, arst_n, res_push && res_full,
		"result pushed into a full queue")
	`TCW_ASSERT(a_copy_phase, clk, arst_n,
		copy_valid_s1 |-> (state_q == ST_COPY) || (state_q == ST_BLANK),
		"scroll copy write outside scroll")

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: front stage, command queue, back end, result queue.
//
// Commands enter through a queue-like port: a transaction is taken when push is high
// and full is low. Each command yields exactly one result, read through empty/pop in
// command order. Colours are set through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this. A command
// passes through the front register, where it waits while the command queue is full.
// In the back end a newline, carriage return or ignored command is handled in the idle
// state, a read fetches the cell from memory and then returns it, and a printable
// character first updates the cursor, then writes the cell; the back end takes the next
// command only after that write. A character that scrolls the screen copies each cell
// below the top row up one row, then blanks the bottom row and writes the character.
// A clear makes one memory write per cell. After reset the screen memory is swept once;
// full stays high throughout, while colour writes are still taken. When the receiver
// stops popping, the result queue fills, the back end stops taking commands, and full
// rises once the front register and command queue are occupied; nothing is lost.
module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  tcw_pkg::item_t                       item,
	output logic                                 full,
	output logic                                 empty,
	input  logic                                 pop,
	output tcw_pkg::result_t                     result,
	input  logic                                 cfg_wr_en,
	input  logic [tcw_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]          cfg_data
);

	localparam int QUEUE_DEPTH = 2;

	tcw_pkg::cfg_wr_t  cfg;
	tcw_pkg::op_t      front_op;
	tcw_pkg::op_t      back_op;
	tcw_pkg::result_t  back_res;
	logic              op_push;
	logic              op_full;
	logic              op_empty;
	logic              op_pop;
	logic              res_push;
	logic              res_full;
	logic              init_busy;

	assign cfg.wr_en = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	tcw_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.init_busy (init_busy),
		.op_push   (op_push),
		.op        (front_op),
		.op_full   (op_full)
	);

	tcw_fifo #(
		.WIDTH($bits(tcw_pkg::op_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (front_op),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (back_op),
		.empty  (op_empty)
	);

	tcw_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.op_valid  (!op_empty),
		.op        (back_op),
		.op_pop    (op_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res),
		.init_busy (init_busy)
	);

	tcw_fifo #(
		.WIDTH($bits(tcw_pkg::result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ===== tb/text_console_writer_test.sv =====
// Self-checking testbench for the text console writer, with its own model of the screen.
`timescale 1ns / 1ps

module text_console_writer_test;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int SETTLE_CYCLES = COLS * ROWS + 16;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	tcw_pkg::item_t item = '0;
	logic full;
	logic empty;
	logic pop = 1'b0;
	tcw_pkg::result_t result;
	logic cfg_wr_en = 1'b0;
	logic [tcw_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [tcw_pkg::COLOR_W-1:0] cfg_data = '0;

	tcw_pkg::item_t cmd_backlog[$];
	tcw_pkg::result_t due_replies[$];
	logic in_taken = 1'b0;
	logic steady = 1'b0;
	int rx_hold = 0;
	int errors = 0;

	logic [15:0] screen_mirror [COLS*ROWS];
	int mirror_col = 0;
	int mirror_row = 0;
	logic [tcw_pkg::COLOR_W-1:0] fg_now = tcw_pkg::RESET_FG;
	logic [tcw_pkg::COLOR_W-1:0] bg_now = tcw_pkg::RESET_BG;
	tcw_pkg::result_t want;

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] colour_cell(logic [7:0] ch);
		return {bg_now, fg_now, ch};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < COLS * ROWS; i++)
			screen_mirror[i] = colour_cell(tcw_pkg::BLANK_CHAR);
	endfunction

	function automatic tcw_pkg::result_t console_step(tcw_pkg::item_t it);
		tcw_pkg::result_t r;
		r = '0;
		case (it.cmd)
			tcw_pkg::CMD_PUT: begin
				if (it.char_code == tcw_pkg::NEWLINE_CHAR) begin
					if (mirror_row < ROWS) mirror_row++;
					mirror_col = 0;
				end else if (it.char_code == tcw_pkg::RETURN_CHAR) begin
					mirror_col = 0;
				end else begin
					if (mirror_col >= COLS && mirror_row < ROWS) begin
						mirror_col = 0;
						mirror_row++;
					end
					if (mirror_row >= ROWS) begin
						for (int i = 0; i < (ROWS - 1) * COLS; i++)
							screen_mirror[i] = screen_mirror[i + COLS];
						for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
							screen_mirror[i] = colour_cell(tcw_pkg::BLANK_CHAR);
						mirror_row = ROWS - 1;
						mirror_col = 0;
					end
					screen_mirror[mirror_row * COLS + mirror_col] = colour_cell(it.char_code);
					mirror_col++;
				end
			end
			tcw_pkg::CMD_CLEAR: begin
				blank_screen();
				mirror_col = 0;
				mirror_row = 0;
			end
			tcw_pkg::CMD_READ: begin
				if (it.read_col < COLS && it.read_row < ROWS)
					r.cell_value = screen_mirror[it.read_row * COLS + it.read_col];
			end
			default: ;
		endcase
		r.cursor_col = mirror_col[6:0];
		r.cursor_row = mirror_row[4:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// Sender: a transaction stays offered until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!push || in_taken)) begin
			if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
				item <= cmd_backlog.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			pop <= arst_n && (steady || $urandom_range(99) >= 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= push && !full;
			if (push && !full) due_replies.push_back(console_step(item));
			if (pop && !empty) begin
				if (due_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", result));
				end else begin
					want = due_replies.pop_front();
					if (result.cell_value !== want.cell_value)
						report_mismatch($sformatf("cell_value %h, expected %h",
							result.cell_value, want.cell_value));
					if (result.cursor_col !== want.cursor_col)
						report_mismatch($sformatf("cursor_col %0d, expected %0d",
							result.cursor_col, want.cursor_col));
					if (result.cursor_row !== want.cursor_row)
						report_mismatch($sformatf("cursor_row %0d, expected %0d",
							result.cursor_row, want.cursor_row));
				end
			end
		end
	end

	task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [6:0] col, input logic [4:0] row);
		tcw_pkg::item_t it;
		it.cmd = cmd;
		it.char_code = ch;
		it.read_col = col;
		it.read_row = row;
		cmd_backlog.push_back(it);
	endtask

	task automatic queue_put(input logic [7:0] ch);
		queue_cmd(tcw_pkg::CMD_PUT, ch, 7'($urandom), 5'($urandom));
	endtask

	task automatic set_colour(input logic [tcw_pkg::REG_IDX_W-1:0] idx,
			input logic [tcw_pkg::COLOR_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == tcw_pkg::REG_FG) fg_now = val;
		else bg_now = val;
	endtask

	task automatic drain();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || push || due_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly lines of text, newline runs and reads, with some noise mixed in.
	task automatic add_traffic(input int budget);
		int start;
		int len;
		int pick;
		start = cmd_backlog.size();
		while (cmd_backlog.size() - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = ($urandom_range(99) < 15) ? $urandom_range(75, 170) : $urandom_range(0, 30);
				repeat (len) begin
					if ($urandom_range(99) < 80) queue_put(8'($urandom_range(32, 126)));
					else queue_put(8'($urandom));
				end
				pick = $urandom_range(99);
				if (pick < 80 && pick >= 60) queue_put(tcw_pkg::RETURN_CHAR);
				if (pick < 80) queue_put(tcw_pkg::NEWLINE_CHAR);
				else if (pick < 90) queue_put(tcw_pkg::RETURN_CHAR);
			end else if (pick < 60) begin
				repeat ($urandom_range(1, 30)) queue_put(tcw_pkg::NEWLINE_CHAR);
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(99) < 70)
						queue_cmd(tcw_pkg::CMD_READ, 8'($urandom),
							7'($urandom_range(0, COLS - 1)),
							5'($urandom_range(0, ROWS - 1)));
					else
						queue_cmd(tcw_pkg::CMD_READ, 8'($urandom), 7'($urandom),
							5'($urandom));
				end
			end else if (pick < 82) begin
				queue_cmd(tcw_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
			end else if (pick < 88) begin
				queue_cmd(CMD_SPARE, 8'($urandom), 7'($urandom), 5'($urandom));
			end else begin
				queue_cmd(2'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
			end
		end
	endtask

	initial begin
		blank_screen();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
		queue_cmd(tcw_pkg::CMD_READ, 8'hFF, 7'd79, 5'd24);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd80, 5'd0);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd25);
		queue_cmd(tcw_pkg::CMD_READ, 8'hFF, 7'd127, 5'd31);
		queue_put(8'h41);
		queue_put(8'h00);
		queue_put(8'hFF);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd2, 5'd0);
		queue_put(tcw_pkg::RETURN_CHAR);
		queue_put(8'h42);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
		queue_put(tcw_pkg::NEWLINE_CHAR);
		queue_cmd(CMD_SPARE, 8'hFF, 7'd127, 5'd31);
		queue_put(8'h7E);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd1);
		queue_cmd(tcw_pkg::CMD_CLEAR, 8'h00, 7'd0, 5'd0);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0);
		queue_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd1);
		drain();

		// The receiver holds off while the sender keeps offering, so the block fills up.
		set_colour(tcw_pkg::REG_FG, 4'hF);
		set_colour(tcw_pkg::REG_BG, 4'h0);
		rx_hold = 600;
		add_traffic(300);
		drain();

		set_colour(tcw_pkg::REG_FG, 4'($urandom));
		set_colour(tcw_pkg::REG_BG, 4'($urandom));
		add_traffic(250);
		drain();

		steady = 1'b1;
		set_colour(tcw_pkg::REG_FG, 4'hF);
		set_colour(tcw_pkg::REG_BG, 4'hF);
		add_traffic(250);
		drain();
		steady = 1'b0;

		set_colour(tcw_pkg::REG_FG, 4'h0);
		set_colour(tcw_pkg::REG_BG, 4'h0);
		add_traffic(250);
		drain();

		set_colour(tcw_pkg::REG_FG, 4'($urandom));
		set_colour(tcw_pkg::REG_BG, 4'($urandom));
		add_traffic(250);
		drain();

		if (due_replies.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_replies.size()));
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
